// ===== rtl/core/mswi_pkg.sv =====
// Package with shared types, constants and codes of the waypoint interpolator.
package mswi_pkg;

    localparam int WAYPOINT_DEPTH = 512;
    localparam int CHANNELS       = 8;
    localparam int WIDTH_BITS     = 12;
    localparam int SNAP_MARGIN    = 5;
    localparam int ROW_BITS       = $clog2(WAYPOINT_DEPTH);
    localparam int STEP_BITS      = 16;
    localparam int ROW_WORD_BITS  = CHANNELS * WIDTH_BITS;
    // Product of a width difference and a tick count.
    localparam int PROD_BITS      = WIDTH_BITS + STEP_BITS;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic       CFG_STEP_COUNT    = 1'b0;
    localparam logic       CFG_LAST_WAYPOINT = 1'b1;

    localparam logic [STEP_BITS-1:0] STEP_COUNT_RESET = 16'd500;

    typedef logic [WIDTH_BITS-1:0] t_width;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  waypoint_index;
        logic [11:0] chan0_value;
        logic [11:0] chan1_value;
        logic [11:0] chan2_value;
        logic [11:0] chan3_value;
        logic [11:0] chan4_value;
        logic [11:0] chan5_value;
        logic [11:0] chan6_value;
        logic [11:0] chan7_value;
    } t_in_item;

    typedef struct packed {
        logic [11:0] chan0_width;
        logic [11:0] chan1_width;
        logic [11:0] chan2_width;
        logic [11:0] chan3_width;
        logic [11:0] chan4_width;
        logic [11:0] chan5_width;
        logic [11:0] chan6_width;
        logic [11:0] chan7_width;
        logic        playing;
        logic        sequence_done;
    } t_out_item;

    // Command from the sequencer to every lane.
    typedef struct packed {
        logic                 start;
        logic                 home;
        logic [STEP_BITS-1:0] tick;
        logic [STEP_BITS-1:0] divisor;
    } t_lane_cmd;

    // Home widths after reset.
    function automatic t_width home_width(input int idx);
        unique case (idx)
            0: home_width = t_width'(1490);
            1: home_width = t_width'(1455);
            2: home_width = t_width'(1530);
            3: home_width = t_width'(1480);
            4: home_width = t_width'(1950);
            5: home_width = t_width'(1890);
            6: home_width = t_width'(1910);
            default: home_width = t_width'(830);
        endcase
    endfunction

endpackage

// ===== rtl/core/mswi_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mswi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mswi_lane.sv =====
// One channel lane: snap test, bit-serial interpolation divide and width register.
module mswi_lane import mswi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_cmd i_cmd,
    input  t_width    i_home_w,
    input  t_width    i_start_w,
    input  t_width    i_target_w,
    output t_width    o_width,
    output logic      o_arrived,
    output logic      o_busy
);

    localparam int CNT_BITS = $clog2(PROD_BITS + 1);

    t_width                 r_width, n_width;
    logic                   r_busy, n_busy;
    logic                   r_arrived, n_arrived;
    logic                   r_neg, n_neg;
    logic [PROD_BITS-1:0]   r_prod, n_prod;
    logic [STEP_BITS:0]     r_rem, n_rem;
    logic [PROD_BITS-1:0]   r_quo, n_quo;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    t_width                 r_base, n_base;

    t_width               diff_w;
    t_width               mag;
    logic [STEP_BITS:0]   shifted;
    logic [PROD_BITS:0]   qfix;
    logic signed [PROD_BITS+1:0] value;

    // Distance from the current width to the target, and segment magnitude.
    assign diff_w  = (r_width >= i_target_w) ? r_width - i_target_w : i_target_w - r_width;
    assign mag     = (i_target_w >= i_start_w) ? i_target_w - i_start_w
                                               : i_start_w - i_target_w;
    assign shifted = {r_rem[STEP_BITS-1:0], r_prod[PROD_BITS-1]};
    // Round the quotient up for a falling segment with a remainder.
    assign qfix    = {1'b0, r_quo} + {{PROD_BITS{1'b0}}, (r_neg && (r_rem != '0))};
    assign value   = r_neg ? $signed({3'b000, r_base}) - $signed({1'b0, qfix})
                           : $signed({3'b000, r_base}) + $signed({1'b0, qfix});

    // Next state of the lane.
    always_comb begin
        n_width   = r_width;
        n_busy    = r_busy;
        n_arrived = r_arrived;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_base    = r_base;
        if (i_cmd.start) begin
            n_base = i_start_w;
            n_neg  = i_target_w < i_start_w;
            if ((diff_w < t_width'(SNAP_MARGIN)) || (diff_w == '0)) begin
                n_width   = i_target_w;
                n_arrived = 1'b1;
                n_busy    = 1'b0;
            end else begin
                n_arrived = 1'b0;
                n_busy    = 1'b1;
                n_prod    = PROD_BITS'(mag) * PROD_BITS'(i_cmd.tick);
                n_rem     = '0;
                n_quo     = '0;
                n_cnt     = CNT_BITS'(PROD_BITS);
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                // One restoring-division step a cycle.
                n_prod = {r_prod[PROD_BITS-2:0], 1'b0};
                if (shifted >= {1'b0, i_cmd.divisor}) begin
                    n_rem = shifted - {1'b0, i_cmd.divisor};
                    n_quo = {r_quo[PROD_BITS-2:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_quo = {r_quo[PROD_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_busy = 1'b0;
                if (value < 0) begin
                    n_width = '0;
                end else if (value > $signed({3'b000, {WIDTH_BITS{1'b1}}})) begin
                    n_width = '1;
                end else begin
                    n_width = t_width'(value);
                end
            end
        end
    end

    // Lane registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= i_home_w;
            r_busy    <= 1'b0;
            r_arrived <= 1'b0;
        end else begin
            r_width   <= i_cmd.home ? i_home_w : n_width;
            r_busy    <= n_busy;
            r_arrived <= n_arrived;
        end
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_base <= n_base;
    end

    assign o_width   = r_width;
    assign o_arrived = r_arrived;
    assign o_busy    = r_busy;

endmodule

// ===== rtl/core/multi_servo_waypoint_interpolator_unit.sv =====
// Top level: waypoint table, playback sequencer, eight lanes and result merge.
//
//  channel | valid / ready      | payload
//  in      | i_in_valid/o_in_ready   | t_in_item
//  out     | o_out_valid/i_out_ready | t_out_item
//  cfg     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load, start or ignored request goes straight to the output state, which then sets the valid.
// A tick passes through two table reads of the start and target rows, a lane start,
// 28 bit-serial divide steps and a finish step in every lane, the wait exit, the merge
// and the output state before its result is offered; a lane that snaps skips the divide.
// Reset is synchronous and active low; the table is not cleared.
// One request is in work at a time; a held result stalls the next input.
module multi_servo_waypoint_interpolator_unit import mswi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDS   = 3'd1;
    localparam logic [2:0] ST_RDT   = 3'd2;
    localparam logic [2:0] ST_LANE  = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_MERGE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [STEP_BITS-1:0] r_step_count;
    logic [ROW_BITS-1:0]  r_last_wp;
    logic [ROW_BITS-1:0]  r_start_row, r_target_row;
    logic [STEP_BITS-1:0] r_tick;
    logic                 r_time_flag, r_arr_flag, r_playing, r_done;
    t_width               r_start_w [CHANNELS];
    t_out_item            out_item;

    logic                 accept_in;
    logic                 we;
    logic [ROW_BITS-1:0]  raddr;
    logic [ROW_WORD_BITS-1:0] wdata, rdata;
    t_lane_cmd            cmd;
    t_width               lane_w [CHANNELS];
    logic [CHANNELS-1:0]  lane_arr, lane_busy;
    logic [STEP_BITS-1:0] div;
    logic [STEP_BITS-1:0] tick_inc;

    assign accept_in   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && !o_out_valid;
    assign o_cfg_ready = 1'b1;
    assign div         = (r_step_count == '0) ? STEP_BITS'(1) : r_step_count;
    assign tick_inc    = (r_tick == '1) ? r_tick : r_tick + 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= STEP_COUNT_RESET;
            r_last_wp    <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STEP_COUNT) begin
                r_step_count <= i_cfg_data;
            end else begin
                r_last_wp <= i_cfg_data[ROW_BITS-1:0];
            end
        end
    end

    // Waypoint table, one row of all channels per word.
    assign we    = accept_in && (i_in_data.mode == MODE_LOAD);
    assign wdata = {i_in_data.chan7_value, i_in_data.chan6_value, i_in_data.chan5_value,
                    i_in_data.chan4_value, i_in_data.chan3_value, i_in_data.chan2_value,
                    i_in_data.chan1_value, i_in_data.chan0_value};
    assign raddr = (r_state == ST_IDLE) ? r_start_row : r_target_row;

    mswi_ram #(.WIDTH(ROW_WORD_BITS), .DEPTH(WAYPOINT_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(i_in_data.waypoint_index),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Lane command.
    assign cmd.start   = (r_state == ST_LANE);
    assign cmd.home    = 1'b0;
    assign cmd.tick    = r_tick;
    assign cmd.divisor = div;

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            mswi_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (cmd),
                .i_home_w  (home_width(g)),
                .i_start_w (r_start_w[g]),
                .i_target_w(rdata[g*WIDTH_BITS +: WIDTH_BITS]),
                .o_width   (lane_w[g]),
                .o_arrived (lane_arr[g]),
                .o_busy    (lane_busy[g])
            );
        end
    endgenerate

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept_in) begin
                n_state = ((i_in_data.mode == MODE_TICK) && r_playing) ? ST_RDS : ST_OUT;
            end
            ST_RDS:   n_state = ST_RDT;
            ST_RDT:   n_state = ST_LANE;
            ST_LANE:  n_state = ST_WAIT;
            ST_WAIT:  if (lane_busy == '0) begin
                n_state = ST_MERGE;
            end
            ST_MERGE: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Playback control and merge of lane flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start_row  <= '0;
            r_target_row <= '0;
            r_tick       <= '0;
            r_time_flag  <= 1'b0;
            r_arr_flag   <= 1'b0;
            r_playing    <= 1'b0;
            r_done       <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept_in) begin
                        r_done <= 1'b0;
                        if (i_in_data.mode == MODE_START) begin
                            r_start_row  <= '0;
                            r_target_row <= '0;
                            r_tick       <= '0;
                            r_time_flag  <= 1'b0;
                            r_arr_flag   <= 1'b0;
                            r_playing    <= 1'b1;
                        end else if ((i_in_data.mode == MODE_TICK) && r_playing) begin
                            r_tick <= tick_inc;
                            if (tick_inc >= div) begin
                                r_time_flag <= 1'b1;
                            end
                        end
                    end
                end
                ST_MERGE: begin
                    if ((r_time_flag) && (r_arr_flag || (lane_arr == '1))) begin
                        r_time_flag <= 1'b0;
                        r_arr_flag  <= 1'b0;
                        r_tick      <= '0;
                        if ((r_target_row == r_last_wp) || (r_target_row == '1)) begin
                            r_playing    <= 1'b0;
                            r_start_row  <= '0;
                            r_target_row <= '0;
                            r_done       <= 1'b1;
                        end else begin
                            r_start_row  <= r_target_row;
                            r_target_row <= r_target_row + 1'b1;
                        end
                    end else if (lane_arr == '1) begin
                        r_arr_flag <= 1'b1;
                    end
                end
                ST_OUT: begin
                    o_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Start-row widths arrive from the table in the cycle after the start-row read.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RDS) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_start_w[c] <= rdata[c*WIDTH_BITS +: WIDTH_BITS];
            end
        end
    end

    // Result fields gathered from the lanes and the sequencer.
    always_comb begin
        out_item.chan0_width   = lane_w[0];
        out_item.chan1_width   = lane_w[1];
        out_item.chan2_width   = lane_w[2];
        out_item.chan3_width   = lane_w[3];
        out_item.chan4_width   = lane_w[4];
        out_item.chan5_width   = lane_w[5];
        out_item.chan6_width   = lane_w[6];
        out_item.chan7_width   = lane_w[7];
        out_item.playing       = r_playing;
        out_item.sequence_done = r_done;
    end
    assign o_out_data = out_item;

    // A result is only offered while the sequencer is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == ST_IDLE))
        else $error("result offered during work");

    // Lanes never run while the sequencer is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (lane_busy == '0))
        else $error("lane busy while idle");

    // Done is reported only with playback stopped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sequence_done) |-> !o_out_data.playing)
        else $error("done while playing");

endmodule
